// ===== rtl/core/isrb_pkg.sv =====
// Package for the I2C slave register bank: bank size, event codes,
// memory request type and pointer step functions. No dependencies.
`default_nettype none
package isrb_pkg;

	localparam int REG_COUNT = 255;
	localparam int PTR_W     = 8;
	localparam int DATA_W    = 8;
	localparam int ADDR_W    = $clog2(REG_COUNT);

	localparam logic [2:0] EV_ADDR = 3'd0;
	localparam logic [2:0] EV_RX   = 3'd1;
	localparam logic [2:0] EV_TX   = 3'd2;
	localparam logic [2:0] EV_NACK = 3'd3;
	localparam logic [2:0] EV_STOP = 3'd4;

	localparam logic [PTR_W-1:0]  PTR_CNT    = PTR_W'(REG_COUNT);
	localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(REG_COUNT - 1);
	localparam logic [DATA_W-1:0] BYTE_EMPTY = 8'hFF;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	function automatic logic ptr_in_range(input logic [PTR_W-1:0] p);
		return p < PTR_CNT;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = p + PTR_W'(1);
		return (n >= PTR_CNT) ? '0 : n;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = p - PTR_W'(1);
		return (n >= PTR_CNT) ? PTR_LAST : n;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/i2c_slave_register_bank.sv =====
// Top level of the I2C slave register bank. Uses isrb_pkg, isrb_ram, isrb_ctrl.
// An accepted event is registered with its bank read, executes in EXEC, then
// its result is registered and strobed on done. Busy blocks a new event during the bank
// RAM read-modify-write (read at accept; write back, pointer update the next cycle).
// Reset: pointer 0, next byte loads the pointer, bank reads as zero through
// per-entry valid bits cleared at once; no clearing pass.
`default_nettype none
module i2c_slave_register_bank import isrb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output      logic              busy,
	input  wire logic [2:0]        func,
	input  wire logic [DATA_W-1:0] rx_byte,
	output      logic              done,
	output      logic [DATA_W-1:0] tx_byte,
	output      logic              tx_valid,
	output      logic              tx_flush
);

	mem_req_t          mem_req;
	logic [DATA_W-1:0] mem_rdata;

	isrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.func      (func),
		.rx_byte   (rx_byte),
		.busy      (busy),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.done      (done),
		.tx_byte   (tx_byte),
		.tx_valid  (tx_valid),
		.tx_flush  (tx_flush)
	);

	isrb_ram #(
		.WIDTH (DATA_W),
		.DEPTH (REG_COUNT)
	) u_bank (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire

// ===== rtl/core/isrb_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module isrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/isrb_ctrl.sv =====
// Event sequencer: pointer, pointer-load flag, entry valid bits and result
// registers; issues read at accept, writes back in the next cycle. Uses isrb_pkg.
`default_nettype none
module isrb_ctrl import isrb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [2:0]        func,
	input  wire logic [DATA_W-1:0] rx_byte,
	output      logic              busy,
	output      mem_req_t          mem_req,
	input  wire logic [DATA_W-1:0] mem_rdata,
	output      logic              done,
	output      logic [DATA_W-1:0] tx_byte,
	output      logic              tx_valid,
	output      logic              tx_flush
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                 state_q;
	logic [PTR_W-1:0]     ptr_q;
	logic                 expect_q;
	logic [REG_COUNT-1:0] vld_q;
	logic [2:0]           func_s1;
	logic [DATA_W-1:0]    rx_s1;
	logic                 done_q;
	logic [DATA_W-1:0]    tx_byte_q;
	logic                 tx_valid_q;
	logic                 tx_flush_q;

	logic                 accept;
	logic                 exec;
	logic                 in_range;
	logic [ADDR_W-1:0]    addr;
	logic                 wr;
	logic [DATA_W-1:0]    rd_byte;

	assign busy     = (state_q == ST_EXEC);
	assign accept   = start && !busy;
	assign exec     = (state_q == ST_EXEC);
	assign in_range = ptr_in_range(ptr_q);
	assign addr     = ptr_q[ADDR_W-1:0];
	assign wr       = exec && (func_s1 == EV_RX) && !expect_q && in_range;
	assign rd_byte  = (in_range && vld_q[addr]) ? mem_rdata : '0;

	assign mem_req.we    = wr;
	assign mem_req.re    = accept;
	assign mem_req.addr  = addr;
	assign mem_req.wdata = rx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			rx_s1   <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			expect_q <= 1'b1;
			vld_q    <= '0;
		end else if (exec) begin
			if (wr) begin
				vld_q[addr] <= 1'b1;
			end
			case (func_s1)
				EV_ADDR: expect_q <= 1'b1;
				EV_RX: begin
					if (expect_q) begin
						ptr_q    <= rx_s1;
						expect_q <= 1'b0;
					end else begin
						ptr_q <= ptr_inc(ptr_q);
					end
				end
				EV_TX:   if (in_range) ptr_q <= ptr_inc(ptr_q);
				EV_NACK: ptr_q <= ptr_dec(ptr_q);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			tx_byte_q  <= '0;
			tx_valid_q <= 1'b0;
			tx_flush_q <= 1'b0;
		end else begin
			done_q     <= exec;
			tx_valid_q <= exec && (func_s1 == EV_TX);
			tx_flush_q <= exec && (func_s1 == EV_STOP);
			if (exec && (func_s1 == EV_TX)) begin
				tx_byte_q <= in_range ? rd_byte : BYTE_EMPTY;
			end else begin
				tx_byte_q <= '0;
			end
		end
	end

	assign done     = done_q;
	assign tx_byte  = tx_byte_q;
	assign tx_valid = tx_valid_q;
	assign tx_flush = tx_flush_q;

endmodule
`default_nettype wire

// ===== rtl/core/isrb_checker.sv =====
// Port-level checker for the I2C slave register bank, bound to the top level.
// Uses isrb_pkg.
`default_nettype none
module isrb_checker import isrb_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic [2:0]        func,
	input wire logic [DATA_W-1:0] rx_byte,
	input wire logic              done,
	input wire logic [DATA_W-1:0] tx_byte,
	input wire logic              tx_valid,
	input wire logic              tx_flush
);

	logic accept;
	assign accept = start && !busy;

	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("result strobe missing two cycles after accept");

	a_done_only_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 2))
		else $error("result strobe without accepted event");

	a_quiet_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (tx_byte == '0) && !tx_valid && !tx_flush)
		else $error("result fields active without strobe");

	a_tx_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tx_valid == ($past(func, 2) == EV_TX))
			&& (tx_flush == ($past(func, 2) == EV_STOP)))
		else $error("result kind does not match event");

	a_idle_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !tx_valid) |-> (tx_byte == '0))
		else $error("tx_byte nonzero on non-transmit result");

endmodule

bind i2c_slave_register_bank isrb_checker u_isrb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.func     (func),
	.rx_byte  (rx_byte),
	.done     (done),
	.tx_byte  (tx_byte),
	.tx_valid (tx_valid),
	.tx_flush (tx_flush)
);
`default_nettype wire

// ===== bench/i2c_slave_register_bank_checker.sv =====
// Checker for the I2C slave register bank: watches accepted bus events and done strobes,
// predicts each transmit word from its own pointer and bank copy, and counts mismatches.
// Depends on isrb_pkg for the bank size and event codes.
module i2c_slave_register_bank_checker import isrb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  func,
	input  logic [7:0]  rx_byte,
	input  logic        done,
	input  logic [7:0]  tx_byte,
	input  logic        tx_valid,
	input  logic        tx_flush,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       tx_flush;
	} tx_word_t;

	tx_word_t   tx_expected[$];
	logic [7:0] ptr_model;
	logic       load_ptr;
	logic [7:0] bank_model [REG_COUNT];

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	function automatic logic [7:0] ptr_up(input logic [7:0] p);
		logic [7:0] n;
		n = p + 8'd1;
		if (n >= REG_COUNT)
			n = 8'd0;
		return n;
	endfunction

	function automatic tx_word_t bus_event(input logic [2:0] ev, input logic [7:0] data);
		tx_word_t   w;
		logic [7:0] n;
		w = '0;
		case (ev)
			EV_ADDR: begin
				load_ptr = 1'b1;
			end
			EV_RX: begin
				if (load_ptr) begin
					ptr_model = data;
					load_ptr  = 1'b0;
				end else begin
					if (ptr_model < REG_COUNT)
						bank_model[ptr_model] = data;
					ptr_model = ptr_up(ptr_model);
				end
			end
			EV_TX: begin
				w.tx_valid = 1'b1;
				if (ptr_model < REG_COUNT) begin
					w.tx_byte = bank_model[ptr_model];
					ptr_model = ptr_up(ptr_model);
				end else begin
					w.tx_byte = BYTE_EMPTY;
				end
			end
			EV_NACK: begin
				n = ptr_model - 8'd1;
				if (n >= REG_COUNT)
					n = 8'(REG_COUNT - 1);
				ptr_model = n;
			end
			EV_STOP: begin
				w.tx_flush = 1'b1;
			end
			default: ;
		endcase
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tx_word_t w;
		if (!arst_n) begin
			ptr_model = '0;
			load_ptr  = 1'b1;
			for (int i = 0; i < REG_COUNT; i++)
				bank_model[i] = '0;
			tx_expected.delete();
			outstanding = 0;
		end else begin
			if (done) begin
				if (tx_expected.size() == 0) begin
					$error("done strobe with no word expected");
					fail_count++;
				end else begin
					w = tx_expected.pop_front();
					if (tx_byte !== w.tx_byte) begin
						$error("tx_byte: expected %02h, actual %02h", w.tx_byte, tx_byte);
						fail_count++;
					end
					if (tx_valid !== w.tx_valid) begin
						$error("tx_valid: expected %0b, actual %0b", w.tx_valid, tx_valid);
						fail_count++;
					end
					if (tx_flush !== w.tx_flush) begin
						$error("tx_flush: expected %0b, actual %0b", w.tx_flush, tx_flush);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				tx_expected.push_back(bus_event(func, rx_byte));
			outstanding = tx_expected.size();
		end
	end

endmodule

// ===== bench/i2c_slave_register_bank_tb.sv =====
// Testbench top for the I2C slave register bank: drives directed and random bus event
// sequences with random gaps; fails after an idle limit, else judges by the checker's failure count.
// Depends on isrb_pkg, i2c_slave_register_bank and i2c_slave_register_bank_checker.
module i2c_slave_register_bank_tb;
	import isrb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] EV_TIMEOUT = 3'd5;
	localparam logic [2:0] EV_SPARE6  = 3'd6;
	localparam logic [2:0] EV_SPARE7  = 3'd7;
	localparam int RANDOM_ITEMS = 1250;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [2:0] func = '0;
	logic [7:0] rx_byte = '0;
	logic       busy;
	logic       done;
	logic [7:0] tx_byte;
	logic       tx_valid;
	logic       tx_flush;
	int         fail_count;
	int         outstanding;
	int         idle_cycles = 0;
	int         no_gap_left = 0;
	int         random_items = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	i2c_slave_register_bank dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .rx_byte(rx_byte), .done(done),
		.tx_byte(tx_byte), .tx_valid(tx_valid), .tx_flush(tx_flush)
	);

	i2c_slave_register_bank_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .rx_byte(rx_byte), .done(done),
		.tx_byte(tx_byte), .tx_valid(tx_valid), .tx_flush(tx_flush),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("i2c_slave_register_bank test failed");
			$finish;
		end
	end

	task automatic send_word(input logic [2:0] ev, input logic [7:0] data);
		int gap;
		if (no_gap_left > 0) begin
			gap = 0;
			no_gap_left--;
		end else begin
			gap = $urandom_range(0, 15);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		func    <= ev;
		rx_byte <= data;
		do @(posedge clk); while (busy);
		random_items++;
	endtask

	task automatic send_random_op();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			send_word(EV_RX, 8'($urandom));
		else if (pick < 75)
			send_word(EV_TX, 8'($urandom));
		else if (pick < 90)
			send_word(EV_NACK, 8'($urandom));
		else
			send_word(3'($urandom_range(EV_TIMEOUT, EV_SPARE7)), 8'($urandom));
	endtask

	initial begin
		int         pick;
		int         ops;
		logic [7:0] ptr;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(EV_TX, 8'h00);
		send_word(EV_NACK, 8'h00);
		send_word(EV_TX, 8'h00);
		send_word(EV_ADDR, 8'h00);
		send_word(EV_RX, 8'hFF);
		send_word(EV_RX, 8'hAA);
		send_word(EV_ADDR, 8'h00);
		send_word(EV_RX, 8'hFF);
		send_word(EV_TX, 8'h00);
		send_word(EV_NACK, 8'h00);
		send_word(EV_RX, 8'h5A);
		send_word(EV_ADDR, 8'h00);
		send_word(EV_RX, 8'hFE);
		send_word(EV_TX, 8'h00);
		send_word(EV_RX, 8'hFF);
		send_word(EV_ADDR, 8'hFF);
		send_word(EV_RX, 8'h00);
		send_word(EV_TX, 8'h00);
		send_word(EV_STOP, 8'h00);
		send_word(EV_TIMEOUT, 8'hFF);
		send_word(EV_SPARE6, 8'h55);
		send_word(EV_SPARE7, 8'hAA);
		send_word(EV_ADDR, 8'h00);
		send_word(EV_TX, 8'h00);
		send_word(EV_RX, 8'h80);
		send_word(EV_RX, 8'h7F);
		send_word(EV_NACK, 8'h00);
		send_word(EV_TX, 8'h00);

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				no_gap_left = $urandom_range(20, 60);
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				send_word(EV_ADDR, 8'($urandom));
				pick = $urandom_range(0, 99);
				if (pick < 60)
					ptr = 8'($urandom_range(0, 15));
				else if (pick < 80)
					ptr = 8'($urandom_range(240, 255));
				else
					ptr = 8'($urandom);
				send_word(EV_RX, ptr);
				ops = $urandom_range(1, 8);
				repeat (ops) send_random_op();
				if ($urandom_range(0, 9) < 7)
					send_word(EV_STOP, 8'($urandom));
			end else begin
				ops = $urandom_range(1, 4);
				repeat (ops) send_word(3'($urandom_range(0, 7)), 8'($urandom));
			end
		end
		start <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("i2c_slave_register_bank test passed");
		else
			$display("i2c_slave_register_bank test failed");
		$finish;
	end

endmodule

// ===== i2c_slave_register_bank.f =====
rtl/core/isrb_pkg.sv
rtl/core/isrb_ram.sv
rtl/core/isrb_ctrl.sv
rtl/core/i2c_slave_register_bank.sv
rtl/core/isrb_checker.sv
bench/i2c_slave_register_bank_checker.sv
bench/i2c_slave_register_bank_tb.sv
